>>> hw/rtl/slt_pkg.sv
// Shared types and constants of the sprite list tile placer.
// No dependencies; every other file of the block refers to it by scoped names.
package slt_pkg;

    localparam int ROW_W  = 6;   // row count and row index
    localparam int TILE_W = 5;   // tile row field
    localparam int POS_W  = 10;  // screen positions and screen size registers
    localparam int ZX_W   = 5;   // x zoom, 1..16
    localparam int ZY_W   = 8;   // y zoom, 1..128
    localparam int ACC_W  = 12;  // y accumulator in eighths of a line
    localparam int CFG_W  = 10;  // widest configuration register
    localparam int IN_DW  = 48;  // slave tdata width
    localparam int OUT_DW = 40;  // master tdata width

    localparam logic signed [POS_W:0] X_WRAP    = 11'sd496;  // 0x1f0
    localparam logic signed [POS_W:0] X_SPAN    = 11'sd512;  // 0x200
    localparam logic [POS_W-1:0]      Y_BASE    = 10'h200;
    localparam logic [POS_W-1:0]      Y_OFFSET  = 10'd16;
    localparam logic [CFG_W-1:0]      WIDTH_RST  = 10'd320;
    localparam logic [CFG_W-1:0]      HEIGHT_RST = 10'd224;

    // Configuration register indexes.
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT
    } t_state;

    // One decoded sprite column, handed from the decoder to the row sequencer.
    typedef struct packed {
        logic [ROW_W-1:0]        rows;
        logic signed [POS_W-1:0] sx;
        logic [POS_W-1:0]        sy;
        logic [ZX_W-1:0]         xzoom;
        logic [ZY_W-1:0]         yzoom;
    } t_entry;

endpackage

>>> hw/rtl/sprite_list_tile_placer_core.sv
// Sprite list tile placer: one entry in, one word per tile row out.
// An entry occupies the block from acceptance until the row sequencer drains; the sequencer
// emits one tile row per cycle unless the master side applies back-pressure. The entry word is
// registered, decoded, loaded into the sequencer, and each row leaves through an output register.
// Reset (synchronous, active low) clears the chaining state, empties the output register and
// restores the screen size registers to 320 by 224. Depends on slt_pkg, slt_decode, slt_rows.
module sprite_list_tile_placer_core #(
    parameter int MAX_ROWS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration write port: index 0 screen width, index 1 screen height.
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_index,
    input  logic [slt_pkg::CFG_W-1:0]    i_cfg_data,
    // Sprite list entries.
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // Fields from bit 0: zoom_word[15:0], y_word[31:16], x_word[47:32].
    input  logic [slt_pkg::IN_DW-1:0]    s_axis_tdata,
    // Fields from bit 0: frame_start[0].
    input  logic                         s_axis_tuser,
    // Tile rows.
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // Fields from bit 0: tile_row[4:0], x_pos[14:5], y_pos[24:15],
    // x_scale[29:25], y_scale[34:30], on_screen[35], zero[39:36].
    output logic [slt_pkg::OUT_DW-1:0]   m_axis_tdata,
    // Marks the final tile row of an entry.
    output logic                         m_axis_tlast
);

    // The sequence per entry is: accept the word while idle, decode it in the decode state (which
    // also commits the chaining state), then let the row sequencer drain any rows it has.
    slt_pkg::t_state r_state, n_state;

    logic [slt_pkg::CFG_W-1:0] r_width;
    logic [slt_pkg::CFG_W-1:0] r_height;
    logic [15:0]               r_zoom_word;
    logic [15:0]               r_y_word;
    logic [15:0]               r_x_word;
    logic                      r_frame_start;

    logic                      w_accept;
    logic                      w_load;
    logic                      w_busy;
    slt_pkg::t_entry           w_entry;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            slt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = slt_pkg::ST_DECODE;
                end
            end
            slt_pkg::ST_DECODE: begin
                // An entry without rows has nothing to emit.
                n_state = (w_entry.rows == '0) ? slt_pkg::ST_IDLE : slt_pkg::ST_EMIT;
            end
            slt_pkg::ST_EMIT: begin
                if (!w_busy) begin
                    n_state = slt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slt_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        s_axis_tready = 1'b0;
        w_load        = 1'b0;
        case (r_state)
            slt_pkg::ST_IDLE:   s_axis_tready = 1'b1;
            slt_pkg::ST_DECODE: w_load        = 1'b1;
            slt_pkg::ST_EMIT:   s_axis_tready = 1'b0;
            default:            s_axis_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= slt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Screen size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= slt_pkg::WIDTH_RST;
            r_height <= slt_pkg::HEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                slt_pkg::CFG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                slt_pkg::CFG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default:                    r_width  <= r_width;
            endcase
        end
    end

    // The accepted entry is held here while it is decoded.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_zoom_word   <= s_axis_tdata[15:0];
            r_y_word      <= s_axis_tdata[31:16];
            r_x_word      <= s_axis_tdata[47:32];
            r_frame_start <= s_axis_tuser;
        end
    end

    slt_decode #(
        .MAX_ROWS (MAX_ROWS)
    ) u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_commit      (w_load),
        .i_zoom_word   (r_zoom_word),
        .i_y_word      (r_y_word),
        .i_x_word      (r_x_word),
        .i_frame_start (r_frame_start),
        .o_entry       (w_entry)
    );

    slt_rows u_rows (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_entry       (w_entry),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_busy        (w_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> hw/rtl/slt_decode.sv
// Entry decoder: zoom extraction, chaining to the previous entry and x wrap.
// Holds the previous-entry state. Depends on slt_pkg.
module slt_decode #(
    parameter int MAX_ROWS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_commit,
    input  logic [15:0]         i_zoom_word,
    input  logic [15:0]         i_y_word,
    input  logic [15:0]         i_x_word,
    input  logic                i_frame_start,
    output slt_pkg::t_entry     o_entry
);

    localparam logic [slt_pkg::ROW_W-1:0] ROW_MAX = slt_pkg::ROW_W'(MAX_ROWS);

    logic [slt_pkg::ROW_W-1:0]        r_prev_rows;
    logic signed [slt_pkg::POS_W-1:0] r_prev_x;
    logic [slt_pkg::POS_W-1:0]        r_prev_y;
    logic [slt_pkg::ZX_W-1:0]         r_prev_xzoom;

    logic [slt_pkg::ROW_W-1:0]        w_prev_rows;
    logic signed [slt_pkg::POS_W-1:0] w_prev_x;
    logic [slt_pkg::POS_W-1:0]        w_prev_y;
    logic [slt_pkg::ZX_W-1:0]         w_prev_xzoom;
    logic signed [slt_pkg::POS_W:0]   w_sx;
    logic [slt_pkg::ROW_W-1:0]        w_rows;

    always_comb begin
        // A frame start sees the cleared state.
        w_prev_rows  = i_frame_start ? '0 : r_prev_rows;
        w_prev_x     = i_frame_start ? '0 : r_prev_x;
        w_prev_y     = i_frame_start ? '0 : r_prev_y;
        w_prev_xzoom = i_frame_start ? '0 : r_prev_xzoom;

        o_entry.xzoom = {1'b0, i_zoom_word[11:8]} + 5'd1;
        o_entry.yzoom = {1'b0, i_zoom_word[6:0]} + 8'd1;

        w_rows = i_y_word[5:0];
        if (w_rows > ROW_MAX) begin
            w_rows = ROW_MAX;
        end

        if (i_y_word[6]) begin
            o_entry.rows = w_prev_rows;
            w_sx = $signed({w_prev_x[slt_pkg::POS_W-1], w_prev_x})
                 + $signed({6'b0, w_prev_xzoom});
            o_entry.sy = w_prev_y;
        end else begin
            o_entry.rows = w_rows;
            w_sx = $signed({2'b0, i_x_word[15:7]});
            o_entry.sy = slt_pkg::Y_BASE - {1'b0, i_y_word[15:7]};
        end

        // Columns at the right edge wrap to small negative x.
        if (w_sx >= slt_pkg::X_WRAP) begin
            w_sx = w_sx - slt_pkg::X_SPAN;
        end
        o_entry.sx = w_sx[slt_pkg::POS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_rows  <= '0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_prev_xzoom <= '0;
        end else if (i_commit) begin
            r_prev_rows  <= o_entry.rows;
            r_prev_x     <= o_entry.sx;
            r_prev_y     <= o_entry.sy;
            r_prev_xzoom <= o_entry.xzoom;
        end
    end

endmodule

>>> hw/rtl/slt_rows.sv
// Row sequencer: one shared accumulator adds the y zoom once per tile row.
// Drives the master stream through an output register. Depends on slt_pkg.
module slt_rows (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_load,
    input  slt_pkg::t_entry                  i_entry,
    input  logic [slt_pkg::CFG_W-1:0]        i_width,
    input  logic [slt_pkg::CFG_W-1:0]        i_height,
    output logic                             o_busy,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0: tile_row[4:0], x_pos[14:5], y_pos[24:15],
    // x_scale[29:25], y_scale[34:30], on_screen[35], zero[39:36].
    output logic [slt_pkg::OUT_DW-1:0]       m_axis_tdata,
    output logic                             m_axis_tlast
);

    logic                             r_busy, n_busy;
    logic                             r_valid, n_valid;
    logic [slt_pkg::ROW_W-1:0]        r_row, n_row;
    logic [slt_pkg::ROW_W-1:0]        r_rows;
    logic [slt_pkg::ACC_W-1:0]        r_acc, n_acc;
    logic signed [slt_pkg::POS_W-1:0] r_sx;
    logic [slt_pkg::ZX_W-1:0]         r_xzoom;
    logic [slt_pkg::ZY_W-1:0]         r_yzoom;
    logic [slt_pkg::OUT_DW-1:0]       r_data;
    logic                             r_last;

    logic                             w_adv;
    logic                             w_last;
    logic signed [slt_pkg::POS_W-1:0] w_yy;
    logic                             w_vis;

    assign w_adv  = r_busy && (!r_valid || m_axis_tready);
    assign w_last = (r_row == r_rows - 6'd1);
    assign w_yy   = $signed({1'b0, r_acc[slt_pkg::ACC_W-1:3]} - slt_pkg::Y_OFFSET);
    assign w_vis  = ($signed({r_sx[slt_pkg::POS_W-1], r_sx}) < $signed({1'b0, i_width}))
                 && ($signed({w_yy[slt_pkg::POS_W-1], w_yy}) < $signed({1'b0, i_height}));

    always_comb begin
        n_busy  = r_busy;
        n_row   = r_row;
        n_acc   = r_acc;
        n_valid = r_valid;
        if (m_axis_tready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_busy = (i_entry.rows != '0);
            n_row  = '0;
            n_acc  = {i_entry.sy[8:0], 3'b000};
        end else if (w_adv) begin
            n_valid = 1'b1;
            n_row   = r_row + 6'd1;
            n_acc   = r_acc + {4'b0, r_yzoom};
            if (w_last) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_row   <= '0;
            r_acc   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_row   <= n_row;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rows  <= i_entry.rows;
            r_sx    <= i_entry.sx;
            r_xzoom <= i_entry.xzoom;
            r_yzoom <= i_entry.yzoom;
        end
        if (w_adv) begin
            r_data <= {4'b0, w_vis, r_yzoom[7:3] & 5'h1f, r_xzoom, w_yy, r_sx,
                       r_row[slt_pkg::TILE_W-1:0]};
            r_last <= w_last;
        end
    end

    assign o_busy        = r_busy;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;

endmodule
